@@ rtl/core/dcpp_pkg.sv @@
package dcpp_pkg;

  localparam int DEF_NUM_CAMERAS = 2;
  localparam int DEF_COEF_WIDTH  = 32;
  localparam int DEF_COORD_WIDTH = 18;

  localparam int COEF_IN_W   = 32;
  localparam int IDX_W       = 5;
  localparam int LABEL_W     = 4;
  localparam int PIX_W       = 16;
  localparam int CNT_W       = 2;
  localparam int ROW_COEFS   = 4;
  localparam int CAM_COEFS   = 12;

  localparam logic [CNT_W-1:0] CAM_CNT_RESET = 2'd2;
  localparam logic [CNT_W-1:0] CAM_CNT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] CAM_CNT_TWO   = 2'd2;

  typedef enum logic {
    CMD_PROJECT = 1'b0,
    CMD_COEF_WR = 1'b1
  } cmd_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_t;

endpackage

@@ rtl/core/dual_camera_point_projection.sv @@
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | command, coef_index, coef_value, x/y/z, label
// out_     | output    | out_valid/out_stall| u/v pixel, camera side, label, depth flag
// cfg_     | input     | cfg_we             | camera_count
//
// one request per cycle while no stalled result holds the output; a point passes stages 1 to 5,
// then the 16 one-bit divider stages and the output register
// coefficient writes take effect for the very next accepted point
// synchronous active-low reset clears valid bits and coefficient table, and sets camera count to 2
// the whole pipe freezes only while a result sits stalled in the output register
module dual_camera_point_projection #(
  parameter int NUM_CAMERAS = dcpp_pkg::DEF_NUM_CAMERAS,
  parameter int COEF_WIDTH  = dcpp_pkg::DEF_COEF_WIDTH,
  parameter int COORD_WIDTH = dcpp_pkg::DEF_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dcpp_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [dcpp_pkg::IDX_W-1:0]         in_coef_index,
  input  logic signed [dcpp_pkg::COEF_IN_W-1:0] in_coef_value,
  input  logic signed [COORD_WIDTH-1:0]      in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]      in_y_coord,
  input  logic signed [COORD_WIDTH-1:0]      in_z_coord,
  input  logic [dcpp_pkg::LABEL_W-1:0]       in_label,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dcpp_pkg::PIX_W-1:0]  out_u_pixel,
  output logic signed [dcpp_pkg::PIX_W-1:0]  out_v_pixel,
  output logic                               out_camera_side,
  output logic [dcpp_pkg::LABEL_W-1:0]       out_label_out,
  output logic                               out_depth_invalid
);
  import dcpp_pkg::*;

  localparam int SLOTS = CAM_COEFS * NUM_CAMERAS;
  localparam int PW    = COEF_WIDTH + COORD_WIDTH;       // product width
  localparam int SUMW  = PW + 2;                          // exact sum of four terms
  localparam int ACC_W = (SUMW > 64) ? 64 : SUMW;         // accumulator wraps at 64
  localparam int QB    = PIX_W;                           // quotient bits computed
  localparam int DW    = ACC_W + QB;                      // shifted divisor width

  // global advance: everything moves unless the output holds a stalled result
  logic en;
  logic accept;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  // configuration register
  logic [CNT_W-1:0] cam_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_cnt_r <= CAM_CNT_RESET;
    end else if (cfg_we) begin
      cam_cnt_r <= cfg_wdata;
    end
  end

  // coefficient table, written when a coefficient request is accepted
  logic signed [COEF_WIDTH-1:0] coef_r [SLOTS];
  logic signed [COEF_WIDTH-1:0] coef_wval;
  logic                         coef_we;

  always_comb begin
    if (COEF_WIDTH >= COEF_IN_W) begin
      coef_wval = COEF_WIDTH'(in_coef_value);   // sign extends
    end else begin
      coef_wval = in_coef_value[COEF_WIDTH-1:0];
    end
  end

  assign coef_we = accept && (in_command == CMD_COEF_WR)
                   && ({1'b0, in_coef_index} < (IDX_W+1)'(SLOTS));

  for (genvar s = 0; s < SLOTS; s++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_r[s] <= '0;
      end else if (coef_we && (in_coef_index == IDX_W'(s))) begin
        coef_r[s] <= coef_wval;
      end
    end
  end

  // stage 1: camera choice, coefficient bank selection
  logic side_nxt;
  always_comb begin
    side_nxt = SIDE_RIGHT;
    if (cam_cnt_r == CAM_CNT_ONE) begin
      side_nxt = SIDE_LEFT;
    end else if (cam_cnt_r == CAM_CNT_TWO && !in_y_coord[COORD_WIDTH-1]
                 && (in_y_coord != '0)) begin
      side_nxt = SIDE_LEFT;
    end
    if (NUM_CAMERAS < 2) begin
      side_nxt = SIDE_LEFT;
    end
  end

  logic                          v1_r;
  logic                          side1_r;
  logic [LABEL_W-1:0]            lab1_r;
  logic signed [COORD_WIDTH-1:0] p1_r [3];
  logic signed [COEF_WIDTH-1:0]  m1_r [CAM_COEFS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept && (in_command == CMD_PROJECT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      lab1_r  <= in_label;
      p1_r[0] <= in_x_coord;
      p1_r[1] <= in_y_coord;
      p1_r[2] <= in_z_coord;
    end
  end

  for (genvar k = 0; k < CAM_COEFS; k++) begin : g_msel
    always_ff @(posedge clk) begin
      if (en) begin
        if (side_nxt == SIDE_RIGHT && NUM_CAMERAS > 1) begin
          m1_r[k] <= coef_r[(CAM_COEFS + k) % SLOTS];
        end else begin
          m1_r[k] <= coef_r[k];
        end
      end
    end
  end

  // stage 2: nine products and three offsets
  logic                 v2_r;
  logic                 side2_r;
  logic [LABEL_W-1:0]   lab2_r;
  logic signed [PW-1:0] prod2_r [9];
  logic signed [PW-1:0] off2_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side1_r;
      lab2_r  <= lab1_r;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod2_r[r*3+c] <= PW'(m1_r[r*ROW_COEFS+c]) * PW'(p1_r[c]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        off2_r[r] <= PW'(m1_r[r*ROW_COEFS+3]);
      end
    end
  end

  // stage 3: row sums q0, q1, q2
  logic                    v3_r;
  logic                    side3_r;
  logic [LABEL_W-1:0]      lab3_r;
  logic signed [ACC_W-1:0] q3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side2_r;
      lab3_r  <= lab2_r;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_sum
    logic signed [SUMW-1:0] sum;
    assign sum = SUMW'(prod2_r[r*3]) + SUMW'(prod2_r[r*3+1])
               + SUMW'(prod2_r[r*3+2]) + SUMW'(off2_r[r]);
    always_ff @(posedge clk) begin
      if (en) begin
        q3_r[r] <= sum[ACC_W-1:0];
      end
    end
  end

  // stage 4: signs and magnitudes
  logic               v4_r;
  logic               side4_r;
  logic [LABEL_W-1:0] lab4_r;
  logic [ACC_W-1:0]   nu4_r, nv4_r, d4_r;
  logic               negu4_r, negv4_r, dneg4_r, zero4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      lab4_r  <= lab3_r;
      nu4_r   <= q3_r[0][ACC_W-1] ? (ACC_W)'(-q3_r[0]) : q3_r[0];
      nv4_r   <= q3_r[1][ACC_W-1] ? (ACC_W)'(-q3_r[1]) : q3_r[1];
      d4_r    <= q3_r[2][ACC_W-1] ? (ACC_W)'(-q3_r[2]) : q3_r[2];
      negu4_r <= q3_r[0][ACC_W-1] != q3_r[2][ACC_W-1];
      negv4_r <= q3_r[1][ACC_W-1] != q3_r[2][ACC_W-1];
      dneg4_r <= q3_r[2][ACC_W-1];
      zero4_r <= (q3_r[2] == '0);
    end
  end

  // stage 5: overflow check, quotient at least 2^16 saturates anyway
  logic               v5_r;
  logic               side5_r;
  logic [LABEL_W-1:0] lab5_r;
  logic [ACC_W-1:0]   nu5_r, nv5_r, d5_r;
  logic               negu5_r, negv5_r, dneg5_r, zero5_r, ovfu5_r, ovfv5_r;
  logic [DW-1:0]      dtop;

  assign dtop = {d4_r, {QB{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side4_r;
      lab5_r  <= lab4_r;
      nu5_r   <= nu4_r;
      nv5_r   <= nv4_r;
      d5_r    <= d4_r;
      negu5_r <= negu4_r;
      negv5_r <= negv4_r;
      dneg5_r <= dneg4_r;
      zero5_r <= zero4_r;
      ovfu5_r <= {{QB{1'b0}}, nu4_r} >= dtop;
      ovfv5_r <= {{QB{1'b0}}, nv4_r} >= dtop;
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  logic               dv_r    [QB+1];
  logic               dside_r [QB+1];
  logic [LABEL_W-1:0] dlab_r  [QB+1];
  logic [ACC_W-1:0]   ru_r    [QB+1];
  logic [ACC_W-1:0]   rv_r    [QB+1];
  logic [ACC_W-1:0]   dd_r    [QB+1];
  logic [QB-1:0]      qu_r    [QB+1];
  logic [QB-1:0]      qv_r    [QB+1];
  logic               dnegu_r [QB+1];
  logic               dnegv_r [QB+1];
  logic               dzero_r [QB+1];
  logic               dovfu_r [QB+1];
  logic               dovfv_r [QB+1];
  logic               ddneg_r [QB+1];

  // entry slot 0 is the stage 5 register set
  assign dv_r[0]    = v5_r;
  assign dside_r[0] = side5_r;
  assign dlab_r[0]  = lab5_r;
  assign ru_r[0]    = nu5_r;
  assign rv_r[0]    = nv5_r;
  assign dd_r[0]    = d5_r;
  assign qu_r[0]    = '0;
  assign qv_r[0]    = '0;
  assign dnegu_r[0] = negu5_r;
  assign dnegv_r[0] = negv5_r;
  assign dzero_r[0] = zero5_r;
  assign dovfu_r[0] = ovfu5_r;
  assign dovfv_r[0] = ovfv5_r;
  assign ddneg_r[0] = dneg5_r;

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [DW-1:0] dsh;
    logic          geu, gev;
    assign dsh = {{QB{1'b0}}, dd_r[j]} << B;
    assign geu = {{QB{1'b0}}, ru_r[j]} >= dsh;
    assign gev = {{QB{1'b0}}, rv_r[j]} >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside_r[j+1] <= dside_r[j];
        dlab_r[j+1]  <= dlab_r[j];
        dd_r[j+1]    <= dd_r[j];
        dnegu_r[j+1] <= dnegu_r[j];
        dnegv_r[j+1] <= dnegv_r[j];
        dzero_r[j+1] <= dzero_r[j];
        dovfu_r[j+1] <= dovfu_r[j];
        dovfv_r[j+1] <= dovfv_r[j];
        ddneg_r[j+1] <= ddneg_r[j];
        ru_r[j+1]    <= geu ? ACC_W'({{QB{1'b0}}, ru_r[j]} - dsh) : ru_r[j];
        rv_r[j+1]    <= gev ? ACC_W'({{QB{1'b0}}, rv_r[j]} - dsh) : rv_r[j];
        qu_r[j+1]    <= qu_r[j] | (QB'(geu) << B);
        qv_r[j+1]    <= qv_r[j] | (QB'(gev) << B);
      end
    end
  end

  // output register: sign, saturation, zero depth
  function automatic logic [PIX_W-1:0] sat_q(input logic [QB-1:0] q, input logic ovf,
                                             input logic neg);
    logic [PIX_W-1:0] res;
    if (neg) begin
      if (ovf || q > QB'(32768)) begin
        res = PIX_W'(32768);
      end else begin
        res = PIX_W'(-q);
      end
    end else begin
      if (ovf || q > QB'(32767)) begin
        res = PIX_W'(32767);
      end else begin
        res = q;
      end
    end
    return res;
  endfunction

  logic               vout_r;
  logic [PIX_W-1:0]   u_r, v_r;
  logic               side_r, dinv_r, zero_r;
  logic [LABEL_W-1:0] lab_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= dside_r[QB];
      lab_r  <= dlab_r[QB];
      zero_r <= dzero_r[QB];
      dinv_r <= dzero_r[QB] || ddneg_r[QB];
      if (dzero_r[QB]) begin
        u_r <= '0;
        v_r <= '0;
      end else begin
        u_r <= sat_q(qu_r[QB], dovfu_r[QB], dnegu_r[QB]);
        v_r <= sat_q(qv_r[QB], dovfv_r[QB], dnegv_r[QB]);
      end
    end
  end

  assign out_valid         = vout_r;
  assign out_u_pixel       = u_r;
  assign out_v_pixel       = v_r;
  assign out_camera_side   = side_r;
  assign out_label_out     = lab_r;
  assign out_depth_invalid = dinv_r;

  // checks
  a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (vout_r && zero_r) |-> (u_r == '0 && v_r == '0 && dinv_r))
    else $error("zero depth result not cleared");

  a_one_cam: assert property (@(posedge clk) disable iff (!rst_n)
    (vout_r && NUM_CAMERAS < 2) |-> (side_r == SIDE_LEFT))
    else $error("right camera chosen in single camera build");

  a_cnt_reset: assert property (@(posedge clk)
    (!rst_n && !cfg_we) |=> (cam_cnt_r == CAM_CNT_RESET))
    else $error("camera count not reset");

endmodule
